// File: rtl/fmod_pkg.sv
// Package for the binary32 remainder block: constants, the queue entry type and helpers.
// Used by every module of the block; depends on nothing.
package fmod_pkg;

   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [7:0] EXP_ALL1 = 8'hFF;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   // Kind of work the back end has to do for one request.
   typedef enum logic [1:0] {
      KIND_DIRECT = 2'd0,
      KIND_DIVIDE = 2'd1
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [31:0] direct_bits;
      logic sign;
      logic [23:0] mx;
      logic [23:0] my;
      logic signed [9:0] ex;
      logic signed [9:0] ey;
   } job_type;

   // Count of leading zeros of a 24-bit significand, zero input gives 24.
   function automatic logic [4:0] lzc24(input logic [23:0] m);
      logic [4:0] n;
      logic found;
      n = 5'd24;
      found = 1'b0;
      for (int i = 23; i >= 0; i--) begin
         if (!found && m[i]) begin
            n = 5'(23 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

// File: rtl/fmod_front.sv
// Front end: accepts requests, sorts out the special cases, normalizes operands and queues the jobs.
// Depends on fmod_pkg.
module fmod_front (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [63:0] req_tdata,
   output logic job_valid,
   input  logic job_ready,
   output fmod_pkg::job_type job
);

   fmod_pkg::job_type entry_ff [fmod_pkg::QUEUE_DEPTH];
   fmod_pkg::job_type entry_in;
   logic [fmod_pkg::QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [fmod_pkg::QUEUE_AW:0] count_ff;
   logic [31:0] xb, yb, ax, ay;
   logic [7:0] exf, eyf;
   logic [23:0] mxr, myr;
   logic [4:0] lzx, lzy;
   logic push, pop;

   assign xb = req_tdata[31:0];
   assign yb = req_tdata[63:32];
   assign ax = {1'b0, xb[30:0]};
   assign ay = {1'b0, yb[30:0]};
   assign exf = ax[30:23];
   assign eyf = ay[30:23];
   assign mxr = {exf != 8'd0, ax[22:0]};
   assign myr = {eyf != 8'd0, ay[22:0]};
   assign lzx = fmod_pkg::lzc24(mxr);
   assign lzy = fmod_pkg::lzc24(myr);

   always_comb begin
      entry_in.kind = fmod_pkg::KIND_DIRECT;
      entry_in.direct_bits = xb;
      entry_in.sign = xb[31];
      entry_in.mx = mxr << lzx;
      entry_in.my = myr << lzy;
      entry_in.ex = 10'((exf == 8'd0) ? 10'sd1 : $signed({2'b0, exf})) - $signed({5'b0, lzx});
      entry_in.ey = 10'((eyf == 8'd0) ? 10'sd1 : $signed({2'b0, eyf})) - $signed({5'b0, lzy});
      if ((eyf == fmod_pkg::EXP_ALL1 && ay[22:0] != 23'd0) || exf == fmod_pkg::EXP_ALL1
          || ay == 32'd0) begin
         entry_in.direct_bits = fmod_pkg::QNAN_BITS;
      end else if (eyf == fmod_pkg::EXP_ALL1 || ax < ay) begin
         entry_in.direct_bits = xb;
      end else if (ax == ay) begin
         entry_in.direct_bits = {xb[31], 31'd0};
      end else begin
         entry_in.kind = fmod_pkg::KIND_DIVIDE;
      end
   end

   assign req_tready = count_ff != (fmod_pkg::QUEUE_AW+1)'(fmod_pkg::QUEUE_DEPTH);
   assign push = req_tvalid && req_tready;
   assign job_valid = count_ff != '0;
   assign pop = job_valid && job_ready;
   assign job = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (fmod_pkg::QUEUE_AW+1)'(push) - (fmod_pkg::QUEUE_AW+1)'(pop);
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (fmod_pkg::QUEUE_AW+1)'(fmod_pkg::QUEUE_DEPTH))
      else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> !push) else $error("push into full queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1) else $error("count not advanced");
`endif

endmodule

// File: rtl/fmod_back.sv
// Back end: shift-subtract remainder, one bit per cycle, then normalize and pack; special cases pass straight out.
// Depends on fmod_pkg.
module fmod_back (
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_ready,
   input  fmod_pkg::job_type job,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_NORM = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [24:0] mx_ff, mx_in;
   logic [23:0] my_ff;
   logic signed [9:0] ex_ff, ex_in, ey_ff, ey_in;
   logic sign_ff;
   logic [31:0] res_ff, res_in;
   logic [24:0] diff;
   logic ge;
   logic [10:0] shift;

   assign ge = mx_ff >= {1'b0, my_ff};
   assign diff = ge ? mx_ff - {1'b0, my_ff} : mx_ff;
   assign shift = 11'(11'sd1 - 11'(ey_ff));
   assign job_ready = state_ff == ST_IDLE || (state_ff == ST_OUT && rsp_tready);
   assign rsp_tvalid = state_ff == ST_OUT;
   assign rsp_tdata = res_ff;

   always_comb begin
      state_in = state_ff;
      mx_in = mx_ff;
      ex_in = ex_ff;
      ey_in = ey_ff;
      res_in = res_ff;
      case (state_ff)
         ST_IDLE, ST_OUT: begin
            if (state_ff == ST_OUT && rsp_tready) state_in = ST_IDLE;
            if (job_valid && job_ready) begin
               mx_in = {1'b0, job.mx};
               ex_in = job.ex;
               ey_in = job.ey;
               res_in = job.direct_bits;
               state_in = (job.kind == fmod_pkg::KIND_DIVIDE) ? ST_DIV : ST_OUT;
            end
         end
         ST_DIV: begin
            if (ex_ff > ey_ff) begin
               mx_in = {diff[23:0], 1'b0};
               ex_in = ex_ff - 10'sd1;
            end else begin
               mx_in = diff;
               state_in = ST_NORM;
               if (diff == '0) begin
                  res_in = {sign_ff, 31'd0};
                  state_in = ST_OUT;
               end
            end
         end
         ST_NORM: begin
            if (!mx_ff[23]) begin
               mx_in = {mx_ff[23:0], 1'b0};
               ey_in = ey_ff - 10'sd1;
            end else begin
               state_in = ST_OUT;
               if (ey_ff >= 10'sd1) begin
                  res_in = {sign_ff, ey_ff[7:0], mx_ff[22:0]};
               end else if (shift >= 11'd32) begin
                  res_in = {sign_ff, 31'd0};
               end else begin
                  res_in = {sign_ff, 31'(32'(mx_ff[23:0]) >> shift[4:0])};
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mx_ff <= mx_in;
      ex_ff <= ex_in;
      ey_ff <= ey_in;
      res_ff <= res_in;
      if (job_valid && job_ready) begin
         my_ff <= job.my;
         sign_ff <= job.sign;
      end
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata)) else $error("result changed while held");
   a_div_mx: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> mx_ff < {my_ff, 1'b0}) else $error("partial remainder too large");
`endif

endmodule

// File: rtl/float32_remainder_fmod.sv
// Binary32 remainder block, top level: connects the front end and the back end.
// Depends on fmod_pkg, fmod_front and fmod_back.
//
// A request of x and y yields fmod(x, y) bit for bit. A special case passes through
// the queue and the back end's result register on its way to the result port. A real
// division first runs the shared subtract loop, which does d + 1 subtract steps. Here
// d is the exponent difference of the normalized operands, up to 276 with subnormals.
// Then come n normalization shifts, up to 23. An exactly divisible pair skips the
// normalization step. A two-entry queue lets new requests be taken while the loop
// works.
module float32_remainder_fmod (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [63:0] req_tdata,  // x_bits [31:0], y_bits [63:32]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata   // rem_bits [31:0]
);

   fmod_pkg::job_type job;
   logic job_valid, job_ready;

   fmod_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .job_valid(job_valid), .job_ready(job_ready), .job(job)
   );

   fmod_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job_ready(job_ready), .job(job),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

endmodule
